// ===== rtl/core/congestion_window_controller_macros.svh =====
// ---------------------------------------------------------------------------
// Congestion window controller assertion macros
// Shared assertion wrappers, clocked on clock; CWC_ASSERT is qualified by reset.
// ---------------------------------------------------------------------------
`ifndef CONGESTION_WINDOW_CONTROLLER_MACROS_SVH
`define CONGESTION_WINDOW_CONTROLLER_MACROS_SVH

// checked only outside reset
`define CWC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define CWC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/cwc_pkg.sv =====
// ---------------------------------------------------------------------------
// Congestion window controller package
// Item types, codes, register indexes and shared helpers.
// ---------------------------------------------------------------------------
package cwc_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_PEER_WINDOW = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT     = 2'd2;

   localparam logic CMD_ACK     = 1'b0;
   localparam logic CMD_TIMEOUT = 1'b1;

   localparam logic [15:0] CWND_MAX          = 16'hFFFF;
   localparam logic [1:0]  DUP_LIMIT         = 2'd3;
   localparam logic [15:0] PEER_WINDOW_RESET = 16'd1;
   localparam logic [15:0] THRESHOLD_RESET   = 16'd43;
   localparam logic [31:0] TIMEOUT_RESET     = 32'd2000000;

   typedef enum logic [1:0] {
      PHASE_SLOW_START = 2'd0,
      PHASE_AVOIDANCE  = 2'd1,
      PHASE_RECOVERY   = 2'd2
   } cwc_phase_type;

   typedef struct packed {
      logic        command;
      logic [31:0] ack_number;
      logic        sample_valid;
      logic [31:0] rtt_sample;
   } cwc_req_type;

   typedef struct packed {
      logic [15:0] cwnd_segments;
      logic [15:0] threshold;
      logic [1:0]  control_state;
      logic [31:0] window_base;
      logic        retransmit;
      logic [39:0] timeout_us;
   } cwc_rsp_type;

   typedef struct packed {
      logic new_ack;
      logic retransmit;
   } cwc_event_type;

   function automatic logic [15:0] sat_window(input logic [16:0] value);
      return value[16] ? CWND_MAX : value[15:0];
   endfunction

endpackage

// ===== rtl/core/congestion_window_controller.sv =====
// ---------------------------------------------------------------------------
// Congestion window controller
// Reno style sender window control with RTT based retransmit timeout.
// ---------------------------------------------------------------------------
// Each item passes the input register, then the result register; a held result
// keeps it in the input register and stalls the request side.
// Throughput: one item per cycle while the result side does not stall.
// Reset (synchronous): cwnd 1, ssthresh 43, slow start, base 0,
// timeout 2000000 us, peer window 1; pipeline empty.
// ---------------------------------------------------------------------------
module congestion_window_controller (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  cwc_pkg::cwc_req_type             req_item,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output cwc_pkg::cwc_rsp_type             rsp_item,
   input  logic                             csr_write,
   input  logic [cwc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cwc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import cwc_pkg::*;

   cwc_req_type   req_ff;
   logic          req_valid_ff;
   cwc_rsp_type   rsp_ff;
   cwc_rsp_type   rsp_in;
   logic          rsp_valid_ff;
   logic [15:0]   peer_window_ff;

   logic          advance;
   logic          req_fire;
   logic          threshold_we;
   logic          timeout_we;
   cwc_event_type evt;
   logic [15:0]   cwnd_in;
   logic [15:0]   ssthresh_in;
   logic [1:0]    phase_in;
   logic [31:0]   base_in;
   logic [39:0]   rto_in;

   assign advance   = req_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = req_valid_ff & ~advance;
   assign req_fire  = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      threshold_we = 1'b0;
      timeout_we   = 1'b0;
      case (csr_index)
         CSR_THRESHOLD: threshold_we = csr_write;
         CSR_TIMEOUT:   timeout_we   = csr_write;
         default:       threshold_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peer_window_ff <= PEER_WINDOW_RESET;
      end else if (csr_write && csr_index == CSR_PEER_WINDOW) begin
         peer_window_ff <= csr_data[15:0];
      end
   end

   cwc_window u_window (
      .clock          (clock),
      .reset          (reset),
      .update         (advance),
      .item           (req_ff),
      .peer_window    (peer_window_ff),
      .threshold_we   (threshold_we),
      .threshold_data (csr_data[15:0]),
      .cwnd_in        (cwnd_in),
      .ssthresh_in    (ssthresh_in),
      .phase_in       (phase_in),
      .base_in        (base_in),
      .evt            (evt)
   );

   cwc_rtt u_rtt (
      .clock        (clock),
      .reset        (reset),
      .update       (advance),
      .evt          (evt),
      .sample_valid (req_ff.sample_valid),
      .rtt_sample   (req_ff.rtt_sample),
      .timeout_we   (timeout_we),
      .timeout_data (csr_data),
      .rto_in       (rto_in)
   );

   always_comb begin
      rsp_in.cwnd_segments = cwnd_in;
      rsp_in.threshold     = ssthresh_in;
      rsp_in.control_state = phase_in;
      rsp_in.window_base   = base_in;
      rsp_in.retransmit    = evt.retransmit;
      rsp_in.timeout_us    = rto_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_fire | req_stall;
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_item;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== rtl/core/cwc_window.sv =====
// ---------------------------------------------------------------------------
// Congestion window state
// Window base, cwnd, ssthresh, phase and duplicate-ack count; next values
// are produced combinationally and committed when an item moves on.
// ---------------------------------------------------------------------------
module cwc_window (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 update,
   input  cwc_pkg::cwc_req_type item,
   input  logic [15:0]          peer_window,
   input  logic                 threshold_we,
   input  logic [15:0]          threshold_data,
   output logic [15:0]          cwnd_in,
   output logic [15:0]          ssthresh_in,
   output logic [1:0]           phase_in,
   output logic [31:0]          base_in,
   output cwc_pkg::cwc_event_type evt
);
   import cwc_pkg::*;

   logic [15:0] cwnd_ff;
   logic [15:0] ssthresh_ff;
   logic [1:0]  phase_ff;
   logic [31:0] base_ff;
   logic [1:0]  dup_ff;
   logic [1:0]  dup_in;

   logic        dup_ack;
   logic [16:0] cap;
   logic [16:0] inc;
   logic [15:0] half;

   assign dup_ack = (item.ack_number == (base_ff - 32'd1));
   assign cap     = {peer_window, 1'b0};
   assign inc     = (cap < {1'b0, cwnd_ff}) ? cap : {1'b0, cwnd_ff};
   assign half    = {1'b0, cwnd_ff[15:1]};

   always_comb begin
      cwnd_in     = cwnd_ff;
      ssthresh_in = ssthresh_ff;
      phase_in    = phase_ff;
      base_in     = base_ff;
      dup_in      = dup_ff;
      evt         = '0;
      if (item.command == CMD_TIMEOUT) begin
         phase_in       = PHASE_SLOW_START;
         ssthresh_in    = half;
         cwnd_in        = 16'd1;
         dup_in         = 2'd0;
         evt.retransmit = 1'b1;
      end else if (dup_ack) begin
         if (phase_ff == PHASE_RECOVERY) begin
            cwnd_in = sat_window({1'b0, cwnd_ff} + 17'd1);
         end else if (dup_ff != DUP_LIMIT) begin
            dup_in = dup_ff + 2'd1;
            if (dup_ff == DUP_LIMIT - 2'd1) begin
               ssthresh_in    = half;
               cwnd_in        = half + {14'd0, DUP_LIMIT};
               phase_in       = PHASE_RECOVERY;
               evt.retransmit = 1'b1;
            end
         end
      end else if (item.ack_number >= base_ff) begin
         base_in     = item.ack_number + 32'd1;
         dup_in      = 2'd0;
         evt.new_ack = 1'b1;
         case (phase_ff)
            PHASE_SLOW_START: begin
               if (cwnd_ff >= ssthresh_ff) begin
                  phase_in = PHASE_AVOIDANCE;
                  cwnd_in  = sat_window({1'b0, cwnd_ff} + 17'd1);
               end else begin
                  cwnd_in = sat_window({1'b0, cwnd_ff} + inc);
               end
            end
            PHASE_AVOIDANCE: begin
               cwnd_in = sat_window({1'b0, cwnd_ff} + 17'd1);
            end
            PHASE_RECOVERY: begin
               phase_in = PHASE_AVOIDANCE;
               cwnd_in  = (ssthresh_ff == 16'd0) ? 16'd1 : ssthresh_ff;
            end
            default: begin
               cwnd_in = cwnd_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cwnd_ff     <= 16'd1;
         ssthresh_ff <= THRESHOLD_RESET;
         phase_ff    <= PHASE_SLOW_START;
         base_ff     <= 32'd0;
         dup_ff      <= 2'd0;
      end else if (update) begin
         cwnd_ff     <= cwnd_in;
         ssthresh_ff <= ssthresh_in;
         phase_ff    <= phase_in;
         base_ff     <= base_in;
         dup_ff      <= dup_in;
      end else if (threshold_we) begin
         ssthresh_ff <= threshold_data;
      end
   end

endmodule

// ===== rtl/core/cwc_rtt.sv =====
// ---------------------------------------------------------------------------
// RTT estimator
// Smoothed RTT and variance (both scaled by 8) and the retransmit timeout.
// ---------------------------------------------------------------------------
module cwc_rtt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   update,
   input  cwc_pkg::cwc_event_type evt,
   input  logic                   sample_valid,
   input  logic [31:0]            rtt_sample,
   input  logic                   timeout_we,
   input  logic [31:0]            timeout_data,
   output logic [39:0]            rto_in
);
   import cwc_pkg::*;

   logic [39:0] srtt_ff;
   logic [39:0] rttvar_ff;
   logic [39:0] rto_ff;
   logic        seen_ff;
   logic [39:0] srtt_in;
   logic [39:0] rttvar_in;
   logic        seen_in;

   logic [39:0] sample;
   logic [39:0] mean;
   logic [39:0] abs_err;
   logic        take;

   assign sample  = {8'd0, rtt_sample};
   assign mean    = {3'd0, srtt_ff[39:3]};
   assign abs_err = (sample >= mean) ? (sample - mean) : (mean - sample);
   assign take    = evt.new_ack & sample_valid;

   always_comb begin
      srtt_in   = srtt_ff;
      rttvar_in = rttvar_ff;
      seen_in   = seen_ff;
      rto_in    = rto_ff;
      if (take) begin
         if (!seen_ff) begin
            srtt_in   = {sample[36:0], 3'd0};
            rttvar_in = {sample[37:0], 2'd0};
            seen_in   = 1'b1;
         end else begin
            srtt_in   = srtt_ff - mean + sample;
            rttvar_in = rttvar_ff - {3'd0, rttvar_ff[39:3]} + abs_err;
         end
         rto_in = {3'd0, srtt_in[39:3]} + {1'd0, rttvar_in[39:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         srtt_ff   <= 40'd0;
         rttvar_ff <= 40'd1;
         rto_ff    <= {8'd0, TIMEOUT_RESET};
         seen_ff   <= 1'b0;
      end else if (update) begin
         srtt_ff   <= srtt_in;
         rttvar_ff <= rttvar_in;
         rto_ff    <= rto_in;
         seen_ff   <= seen_in;
      end else if (timeout_we && !seen_ff) begin
         rto_ff <= {8'd0, timeout_data};
      end
   end

endmodule

// ===== rtl/core/cwc_checker.sv =====
// ---------------------------------------------------------------------------
// Congestion window controller checker
// Port level checks on item flow and result consistency.
// ---------------------------------------------------------------------------
`include "congestion_window_controller_macros.svh"

module cwc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input cwc_pkg::cwc_rsp_type             rsp_item
);
   import cwc_pkg::*;

   logic [1:0] in_flight_ff;
   logic [1:0] in_flight_in;
   logic       req_take;
   logic       rsp_take;

   assign req_take     = req_valid & ~req_stall;
   assign rsp_take     = rsp_valid & ~rsp_stall;
   assign in_flight_in = in_flight_ff + {1'b0, req_take} - {1'b0, rsp_take};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= 2'd0;
      end else begin
         in_flight_ff <= in_flight_in;
      end
   end

   `CWC_ASSERT(a_no_invented_item, rsp_valid |-> in_flight_ff != 2'd0, "result without input item")
   `CWC_ASSERT(a_capacity, in_flight_ff != 2'd3, "more than two items held")
   `CWC_ASSERT(a_full_stalls, (in_flight_ff == 2'd2 && rsp_stall) |-> req_stall, "full, not stalled")
   `CWC_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_item)), "held item changed")
   `CWC_ASSERT(a_timeout_window,
      (rsp_valid && rsp_item.retransmit && rsp_item.control_state == PHASE_SLOW_START)
         |-> rsp_item.cwnd_segments == 16'd1, "timeout did not collapse the window")

endmodule

bind congestion_window_controller cwc_checker u_cwc_checker (.*);

// ===== dv/cwc_window_checker.sv =====
// ---------------------------------------------------------------------------
// Congestion window checker
// Watches the event, result and register ports of the controller, keeps its
// own model of the window, threshold, phase, base and RTT estimator, and
// compares every result item field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module cwc_window_checker
   import cwc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  cwc_req_type            req_item,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  cwc_rsp_type            rsp_item,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     mismatches,
   output int                     outstanding
);

   logic [15:0]   peer_window;
   logic [15:0]   cwnd;
   logic [15:0]   ssthresh;
   cwc_phase_type phase;
   logic [31:0]   base;
   logic [1:0]    dups;
   logic [39:0]   srtt8;
   logic [39:0]   rttvar8;
   logic [39:0]   rto;
   logic          rtt_seen;

   cwc_rsp_type   expected_windows[$];

   function automatic logic [15:0] clamp_window(input logic [17:0] value);
      return (value > 18'(CWND_MAX)) ? CWND_MAX : value[15:0];
   endfunction

   task automatic advance_window(input cwc_req_type ev, output cwc_rsp_type res);
      logic [16:0] twice_peer;
      logic [16:0] growth;
      logic [39:0] sample;
      logic [39:0] mean;
      logic [39:0] deviation;
      logic        retx;
      retx = 1'b0;
      if (ev.command == CMD_TIMEOUT) begin
         phase    = PHASE_SLOW_START;
         ssthresh = cwnd >> 1;
         cwnd     = 16'd1;
         dups     = 2'd0;
         retx     = 1'b1;
      end else if (ev.ack_number == base - 32'd1) begin
         if (phase == PHASE_RECOVERY) begin
            cwnd = clamp_window(18'(cwnd) + 18'd1);
         end else if (dups != DUP_LIMIT) begin
            dups = dups + 2'd1;
            if (dups == DUP_LIMIT) begin
               ssthresh = cwnd >> 1;
               cwnd     = clamp_window(18'(ssthresh) + 18'(DUP_LIMIT));
               phase    = PHASE_RECOVERY;
               retx     = 1'b1;
            end
         end
      end else if (ev.ack_number >= base) begin
         base = ev.ack_number + 32'd1;
         dups = 2'd0;
         if (phase == PHASE_SLOW_START) begin
            if (cwnd >= ssthresh) begin
               phase = PHASE_AVOIDANCE;
            end else begin
               twice_peer = {peer_window, 1'b0};
               growth     = (twice_peer < {1'b0, cwnd}) ? twice_peer : {1'b0, cwnd};
               cwnd       = clamp_window(18'(cwnd) + 18'(growth));
            end
         end
         if (phase == PHASE_AVOIDANCE) begin
            cwnd = clamp_window(18'(cwnd) + 18'd1);
         end else if (phase == PHASE_RECOVERY) begin
            phase = PHASE_AVOIDANCE;
            cwnd  = (ssthresh == 16'd0) ? 16'd1 : ssthresh;
         end
         if (ev.sample_valid) begin
            sample = 40'(ev.rtt_sample);
            if (!rtt_seen) begin
               srtt8    = sample << 3;
               rttvar8  = sample << 2;
               rtt_seen = 1'b1;
            end else begin
               mean      = srtt8 >> 3;
               deviation = (sample >= mean) ? sample - mean : mean - sample;
               srtt8     = srtt8 - mean + sample;
               rttvar8   = rttvar8 - (rttvar8 >> 3) + deviation;
            end
            rto = (srtt8 >> 3) + (rttvar8 >> 1);
         end
      end
      res.cwnd_segments = cwnd;
      res.threshold     = ssthresh;
      res.control_state = phase;
      res.window_base   = base;
      res.retransmit    = retx;
      res.timeout_us    = rto;
   endtask

   always @(posedge clock) begin
      cwc_rsp_type want;
      if (reset) begin
         peer_window = PEER_WINDOW_RESET;
         cwnd        = 16'd1;
         ssthresh    = THRESHOLD_RESET;
         phase       = PHASE_SLOW_START;
         base        = 32'd0;
         dups        = 2'd0;
         srtt8       = 40'd0;
         rttvar8     = 40'd1;
         rto         = 40'(TIMEOUT_RESET);
         rtt_seen    = 1'b0;
         mismatches  = 0;
         expected_windows.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_PEER_WINDOW: peer_window = csr_data[15:0];
               CSR_THRESHOLD:   ssthresh = csr_data[15:0];
               CSR_TIMEOUT: begin
                  if (!rtt_seen) rto = 40'(csr_data);
               end
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            advance_window(req_item, want);
            expected_windows.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_windows.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result item: cwnd %0d ssthresh %0d state %0d base %h",
                           rsp_item.cwnd_segments, rsp_item.threshold,
                           rsp_item.control_state, rsp_item.window_base);
            end else begin
               want = expected_windows.pop_front();
               if (rsp_item.cwnd_segments !== want.cwnd_segments ||
                   rsp_item.threshold     !== want.threshold     ||
                   rsp_item.control_state !== want.control_state ||
                   rsp_item.window_base   !== want.window_base   ||
                   rsp_item.retransmit    !== want.retransmit    ||
                   rsp_item.timeout_us    !== want.timeout_us) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("result mismatch: expected cwnd %0d ssthresh %0d state %0d",
                              want.cwnd_segments, want.threshold, want.control_state);
                     $display("   base %h retx %0d rto %0d", want.window_base,
                              want.retransmit, want.timeout_us);
                     $display("   got cwnd %0d ssthresh %0d state %0d base %h retx %0d rto %0d",
                              rsp_item.cwnd_segments, rsp_item.threshold,
                              rsp_item.control_state, rsp_item.window_base,
                              rsp_item.retransmit, rsp_item.timeout_us);
                  end
               end
            end
         end
      end
      outstanding = expected_windows.size();
   end

endmodule

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// Congestion window controller testbench
// Directed ack, duplicate, stale and timeout sequences, then rounds of random
// ack traffic under several register settings with random idling on both
// sides and one long result hold-off; the checker does the scoring.
// ---------------------------------------------------------------------------
module tb;
   import cwc_pkg::*;

   localparam int PRESSURE_ROUND = 9;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   cwc_req_type            req_item;
   logic                   rsp_valid;
   logic                   rsp_stall;
   cwc_rsp_type            rsp_item;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   logic                   hold_draw;
   logic                   hold_long;
   int                     mismatches;
   int                     outstanding;
   int                     traffic_round;
   logic [31:0]            next_base;
   logic                   sender_quiet;

   assign rsp_stall = hold_draw | hold_long;

   congestion_window_controller i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   cwc_window_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("Verification failed");
      $finish;
   end

   function automatic cwc_req_type make_event(input logic cmd, input logic [31:0] ack,
                                              input logic sv, input logic [31:0] rtt);
      cwc_req_type ev;
      ev.command      = cmd;
      ev.ack_number   = ack;
      ev.sample_valid = sv;
      ev.rtt_sample   = rtt;
      return ev;
   endfunction

   function automatic int unsigned draw_gap();
      return sender_quiet ? 0 : $urandom_range(0, 17);
   endfunction

   function automatic logic [31:0] draw_rtt();
      return ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(50, 200000);
   endfunction

   task automatic offer(input cwc_req_type ev, input int unsigned gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= ev;
      do @(posedge clock); while (req_stall);
      if (ev.command == CMD_ACK && ev.ack_number != next_base - 32'd1 &&
          ev.ack_number >= next_base)
         next_base = ev.ack_number + 32'd1;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_traffic(input int unsigned count);
      int unsigned sent;
      int unsigned pick;
      int unsigned run;
      logic [31:0] jump;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            jump = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100000)
                                               : $urandom_range(0, 4);
            offer(make_event(CMD_ACK, next_base + jump, 1'($urandom_range(0, 1)),
                             draw_rtt()), draw_gap());
            sent++;
         end else if (pick < 75) begin
            run = $urandom_range(1, 6);
            repeat (run) begin
               offer(make_event(CMD_ACK, next_base - 32'd1, 1'($urandom_range(0, 1)),
                                $urandom), draw_gap());
               sent++;
            end
         end else if (pick < 83) begin
            offer(make_event(CMD_TIMEOUT, $urandom, 1'($urandom_range(0, 1)), $urandom),
                  draw_gap());
            sent++;
         end else if (pick < 93) begin
            offer(make_event(CMD_ACK, next_base - $urandom_range(2, 5000),
                             1'($urandom_range(0, 1)), draw_rtt()), draw_gap());
            sent++;
         end else begin
            offer(make_event(CMD_ACK, $urandom, 1'($urandom_range(0, 1)), $urandom),
                  draw_gap());
            sent++;
         end
      end
   endtask

   // result side: random hold-off per item, with quiet stretches
   initial begin
      int unsigned pause;
      int unsigned served;
      logic        quiet;
      hold_draw <= 1'b0;
      served = 0;
      quiet  = 1'b0;
      @(negedge reset);
      forever begin
         if (served % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
         pause = quiet ? 0 : $urandom_range(0, 17);
         if (pause != 0) begin
            hold_draw <= 1'b1;
            repeat (pause) @(posedge clock);
         end
         hold_draw <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         served++;
      end
   end

   // long hold-off so the pipeline fills and back-pressures the sender
   initial begin
      hold_long <= 1'b0;
      wait (traffic_round == PRESSURE_ROUND);
      @(posedge clock);
      hold_long <= 1'b1;
      repeat (150) @(posedge clock);
      hold_long <= 1'b0;
   end

   initial begin
      int unsigned k;
      logic [15:0] peer_pick;
      logic [15:0] thresh_pick;
      logic [31:0] timeout_pick;
      traffic_round = 0;
      next_base     = 32'd0;
      sender_quiet  = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_item  <= '0;
      csr_write <= 1'b0;
      csr_index <= CSR_PEER_WINDOW;
      csr_data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // duplicates at base zero, zero threshold recovery, stale ack, base wrap
      offer(make_event(CMD_ACK, 32'hFFFF_FFFF, 1'b0, 32'd0), draw_gap());
      offer(make_event(CMD_TIMEOUT, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF), draw_gap());
      repeat (4) offer(make_event(CMD_ACK, 32'hFFFF_FFFF, 1'b0, 32'd0), draw_gap());
      offer(make_event(CMD_ACK, 32'd4, 1'b0, 32'd0), draw_gap());
      offer(make_event(CMD_ACK, 32'd2, 1'b1, 32'd77), draw_gap());
      offer(make_event(CMD_ACK, 32'd4, 1'b1, 32'd99), draw_gap());
      offer(make_event(CMD_ACK, 32'hFFFF_FFFF, 1'b0, 32'd0), draw_gap());
      offer(make_event(CMD_TIMEOUT, 32'd0, 1'b0, 32'd0), draw_gap());
      settle();

      write_csr(CSR_PEER_WINDOW, 32'h0000_FFFF);
      write_csr(CSR_THRESHOLD, 32'h0000_FFFF);
      write_csr(CSR_TIMEOUT, 32'hFFFF_FFFF);

      // slow start ramp to saturation, RTT extremes on the first samples
      for (k = 0; k < 17; k++) begin
         case (k)
            0:       offer(make_event(CMD_ACK, k, 1'b1, 32'hFFFF_FFFF), draw_gap());
            1:       offer(make_event(CMD_ACK, k, 1'b1, 32'd0), draw_gap());
            2:       offer(make_event(CMD_ACK, k, 1'b0, 32'd0), draw_gap());
            default: offer(make_event(CMD_ACK, k, 1'b1, draw_rtt()), draw_gap());
         endcase
      end
      settle();

      for (k = 0; k < 8; k++) begin
         traffic_round = k + 1;
         sender_quiet  = (k % 3 == 2);
         case (k % 4)
            0:       peer_pick = 16'd1;
            1:       peer_pick = 16'hFFFF;
            2:       peer_pick = 16'($urandom_range(1, 8));
            default: peer_pick = 16'($urandom_range(1, 65535));
         endcase
         case ((k + 1) % 4)
            0:       thresh_pick = 16'd1;
            1:       thresh_pick = 16'hFFFF;
            2:       thresh_pick = 16'($urandom_range(2, 64));
            default: thresh_pick = 16'($urandom_range(1, 65535));
         endcase
         case (k % 3)
            0:       timeout_pick = 32'd1;
            1:       timeout_pick = 32'hFFFF_FFFF;
            default: timeout_pick = $urandom_range(1, 32'hFFFF_FFFF);
         endcase
         write_csr(CSR_PEER_WINDOW, 32'(peer_pick));
         write_csr(CSR_THRESHOLD, 32'(thresh_pick));
         write_csr(CSR_TIMEOUT, timeout_pick);
         random_traffic(200);
         settle();
      end

      sender_quiet  = 1'b1;
      traffic_round = PRESSURE_ROUND;
      random_traffic(100);
      settle();

      if (mismatches == 0 && outstanding == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
